// ----- hw/rtl/harq_rp_pkg.sv -----
package harq_rp_pkg;

  localparam int NUM_CODEWORDS_DEF = 2;

  localparam int TAG_W   = 32;
  localparam int BYTES_W = 16;
  localparam int TIME_W  = 32;
  localparam int CNT_W   = 4;
  localparam int EVAL_W  = 16;
  localparam int PID_W   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // opcodes
  localparam logic [1:0] OP_INSERT   = 2'd0;
  localparam logic [1:0] OP_POLL     = 2'd1;
  localparam logic [1:0] OP_FEEDBACK = 2'd2;
  localparam logic [1:0] OP_EXTRACT  = 2'd3;

  // slot states
  localparam logic [1:0] SLOT_EMPTY   = 2'd0;
  localparam logic [1:0] SLOT_EVAL    = 2'd1;
  localparam logic [1:0] SLOT_CORRECT = 2'd2;
  localparam logic [1:0] SLOT_CORRUPT = 2'd3;

  // error codes
  localparam logic [2:0] ERR_OK          = 3'd0;
  localparam logic [2:0] ERR_NEW_BUSY    = 3'd1;
  localparam logic [2:0] ERR_RETX_BUSY   = 3'd2;
  localparam logic [2:0] ERR_NOT_EVAL    = 3'd3;
  localparam logic [2:0] ERR_NOT_CORRECT = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETX  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EVAL_INTV = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROC_ID   = 2'd2;

  localparam logic [CNT_W-1:0]  MAX_RETX_RST  = 4'd3;
  localparam logic [EVAL_W-1:0] EVAL_INTV_RST = 16'd3;
  localparam logic [PID_W-1:0]  PROC_ID_RST   = 4'd0;
  localparam logic [CNT_W-1:0]  TX_SAT        = 4'd15;

  typedef struct packed {
    logic [1:0]         opcode;
    logic               codeword;
    logic               new_data;
    logic               decode_ok;
    logic [TAG_W-1:0]   pdu_tag;
    logic [BYTES_W-1:0] pdu_bytes;
    logic [TIME_W-1:0]  now_time;
  } item_t;

  typedef struct packed {
    logic [2:0]         error_code;
    logic [1:0]         slot_state;
    logic               evaluated;
    logic               ack;
    logic               purged;
    logic [PID_W-1:0]   fb_process;
    logic [TAG_W-1:0]   out_tag;
    logic [BYTES_W-1:0] out_bytes;
    logic [CNT_W-1:0]   tx_count;
  } result_t;

  typedef struct packed {
    logic load_in;   // latch accepted input beat
    logic commit;    // update slot state and load result register
  } cmd_t;

  typedef struct packed {
    logic                  wr;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

// ----- hw/rtl/harq_rp_ifs.sv -----
interface harq_rp_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        opcode;
  logic                              codeword;
  logic                              new_data;
  logic                              decode_ok;
  logic [harq_rp_pkg::TAG_W-1:0]     pdu_tag;
  logic [harq_rp_pkg::BYTES_W-1:0]   pdu_bytes;
  logic [harq_rp_pkg::TIME_W-1:0]    now_time;

  modport source (output valid, opcode, codeword, new_data, decode_ok, pdu_tag, pdu_bytes,
                  now_time, input ready);
  modport sink (input valid, opcode, codeword, new_data, decode_ok, pdu_tag, pdu_bytes,
                now_time, output ready);
endinterface

interface harq_rp_out_if;
  logic                              valid;
  logic                              ready;
  logic [2:0]                        error_code;
  logic [1:0]                        slot_state;
  logic                              evaluated;
  logic                              ack;
  logic                              purged;
  logic [harq_rp_pkg::PID_W-1:0]     fb_process;
  logic [harq_rp_pkg::TAG_W-1:0]     out_tag;
  logic [harq_rp_pkg::BYTES_W-1:0]   out_bytes;
  logic [harq_rp_pkg::CNT_W-1:0]     tx_count;

  modport source (output valid, error_code, slot_state, evaluated, ack, purged, fb_process,
                  out_tag, out_bytes, tx_count, input ready);
  modport sink (input valid, error_code, slot_state, evaluated, ack, purged, fb_process,
                out_tag, out_bytes, tx_count, output ready);
endinterface

interface harq_rp_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [harq_rp_pkg::CFG_IDX_W-1:0]    index;
  logic [harq_rp_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/harq_receive_process_core.sv -----
// HARQ receive process with NUM_CODEWORDS codeword slots.
// in_ch  : operation beats (insert, poll, feedback, extract) on a valid/ready channel.
// out_ch : exactly one result beat per accepted operation, in order.
// cfg_ch : register writes (0 max_retx, 1 eval_interval, 2 process_id), always ready;
//          write only while no operation is outstanding.
// The input register takes a beat; the execute state then does the slot read-modify-write
// and loads the result register, from which the result is presented. Execute waits
// while the result register still holds a result that the receiver has not taken.
// One operation is in flight at a time; in_ch.ready is low while it executes.
// When the receiver stalls, the finished result waits in the result register and
// a new beat is still accepted; that beat then waits in execute until the
// result register drains.
// Reset (rst_n low, synchronous): all slots empty, arrival times and decode results
// zero, transmission count zero, registers to max_retx 3, eval_interval 3,
// process_id 0. Stored tags and byte counts are only read after an insert.
module harq_receive_process_core #(
  parameter int NUM_CODEWORDS = harq_rp_pkg::NUM_CODEWORDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  harq_rp_in_if.sink         in_ch,
  harq_rp_out_if.source      out_ch,
  harq_rp_cfg_if.sink        cfg_ch
);

  harq_rp_pkg::cmd_t    cmd;
  harq_rp_pkg::item_t   item;
  harq_rp_pkg::result_t res;
  harq_rp_pkg::cfg_wr_t cfg_wr;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    item.opcode    = in_ch.opcode;
    item.codeword  = in_ch.codeword;
    item.new_data  = in_ch.new_data;
    item.decode_ok = in_ch.decode_ok;
    item.pdu_tag   = in_ch.pdu_tag;
    item.pdu_bytes = in_ch.pdu_bytes;
    item.now_time  = in_ch.now_time;
    cfg_wr.wr      = cfg_ch.valid;
    cfg_wr.index   = cfg_ch.index;
    cfg_wr.data    = cfg_ch.data;
  end

  harq_rp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  harq_rp_dp #(
    .NUM_CODEWORDS (NUM_CODEWORDS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .item   (item),
    .cfg_wr (cfg_wr),
    .res    (res)
  );

  assign out_ch.error_code = res.error_code;
  assign out_ch.slot_state = res.slot_state;
  assign out_ch.evaluated  = res.evaluated;
  assign out_ch.ack        = res.ack;
  assign out_ch.purged     = res.purged;
  assign out_ch.fb_process = res.fb_process;
  assign out_ch.out_tag    = res.out_tag;
  assign out_ch.out_bytes  = res.out_bytes;
  assign out_ch.tx_count   = res.tx_count;

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted while an operation executes");

  a_purge_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.purged |->
      out_ch.slot_state == harq_rp_pkg::SLOT_EMPTY && out_ch.tx_count == '0)
    else $error("purge left slot or count set");

  a_error_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.error_code != harq_rp_pkg::ERR_OK |->
      !out_ch.ack && !out_ch.purged && out_ch.out_tag == '0)
    else $error("failed operation produced feedback");

  a_eval_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.evaluated |-> out_ch.slot_state == harq_rp_pkg::SLOT_EVAL)
    else $error("evaluated flag outside evaluating state");

endmodule

// ----- hw/rtl/harq_rp_ctrl.sv -----
module harq_rp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output harq_rp_pkg::cmd_t   cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic can_commit;

  assign in_ready   = (state_r == ST_IDLE);
  assign out_valid  = out_valid_r;
  // result register is free when empty or drained this cycle
  assign can_commit = (state_r == ST_EXEC) && (!out_valid_r || out_ready);

  always_comb begin
    cmd.load_in = in_valid && in_ready;
    cmd.commit  = can_commit;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC: if (can_commit) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    priority if (can_commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- hw/rtl/harq_rp_dp.sv -----
module harq_rp_dp #(
  parameter int NUM_CODEWORDS = harq_rp_pkg::NUM_CODEWORDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  harq_rp_pkg::cmd_t     cmd,
  input  harq_rp_pkg::item_t    item,
  input  harq_rp_pkg::cfg_wr_t  cfg_wr,
  output harq_rp_pkg::result_t  res
);

  localparam int TW = harq_rp_pkg::TIME_W;
  localparam int CW = harq_rp_pkg::CNT_W;

  harq_rp_pkg::item_t   in_r, in_nxt;
  harq_rp_pkg::result_t res_r, res_nxt;

  logic [1:0]                        st_r    [NUM_CODEWORDS];
  logic [1:0]                        st_nxt  [NUM_CODEWORDS];
  logic [TW-1:0]                     arr_r   [NUM_CODEWORDS];
  logic [TW-1:0]                     arr_nxt [NUM_CODEWORDS];
  logic                              dec_r   [NUM_CODEWORDS];
  logic                              dec_nxt [NUM_CODEWORDS];
  logic [harq_rp_pkg::TAG_W-1:0]     tag_r   [NUM_CODEWORDS];
  logic [harq_rp_pkg::TAG_W-1:0]     tag_nxt [NUM_CODEWORDS];
  logic [harq_rp_pkg::BYTES_W-1:0]   bytes_r   [NUM_CODEWORDS];
  logic [harq_rp_pkg::BYTES_W-1:0]   bytes_nxt [NUM_CODEWORDS];
  logic [CW-1:0]                     tx_r, tx_nxt;
  logic [CW-1:0]                     max_retx_r, max_retx_nxt;
  logic [harq_rp_pkg::EVAL_W-1:0]    eval_r, eval_nxt;
  logic [harq_rp_pkg::PID_W-1:0]     pid_r, pid_nxt;

  logic [NUM_CODEWORDS-1:0]          hit;
  logic                              cw_ok;
  logic [1:0]                        cur_st;
  logic [TW-1:0]                     cur_arr;
  logic                              cur_dec;
  logic [harq_rp_pkg::TAG_W-1:0]     cur_tag;
  logic [harq_rp_pkg::BYTES_W-1:0]   cur_bytes;
  logic [TW-1:0]                     age;
  logic                              age_ok;
  logic                              pre_eval;
  logic                              ins_ok, clr, upd;
  logic [1:0]                        new_st;
  logic [CW-1:0]                     tx_op;

  assign res = res_r;

  // slot select
  always_comb begin
    hit       = '0;
    cur_st    = '0;
    cur_arr   = '0;
    cur_dec   = 1'b0;
    cur_tag   = '0;
    cur_bytes = '0;
    for (int i = 0; i < NUM_CODEWORDS; i++) begin
      hit[i] = (int'(in_r.codeword) == i);
      if (hit[i]) begin
        cur_st    = st_r[i];
        cur_arr   = arr_r[i];
        cur_dec   = dec_r[i];
        cur_tag   = tag_r[i];
        cur_bytes = bytes_r[i];
      end
    end
    cw_ok = |hit;
  end

  assign age      = in_r.now_time - cur_arr;
  assign age_ok   = (age >= TW'(eval_r));
  assign pre_eval = (cur_st == harq_rp_pkg::SLOT_EVAL) && age_ok;

  // operation decode
  always_comb begin
    res_nxt = '0;
    ins_ok  = 1'b0;
    clr     = 1'b0;
    new_st  = cur_st;
    tx_op   = tx_r;
    unique case (in_r.opcode)
      harq_rp_pkg::OP_INSERT: begin
        priority if (in_r.new_data && cur_st != harq_rp_pkg::SLOT_EMPTY) begin
          res_nxt.error_code = harq_rp_pkg::ERR_NEW_BUSY;
        end else if (!in_r.new_data && (cur_st == harq_rp_pkg::SLOT_EVAL ||
                                        cur_st == harq_rp_pkg::SLOT_CORRECT)) begin
          res_nxt.error_code = harq_rp_pkg::ERR_RETX_BUSY;
        end else begin
          ins_ok = 1'b1;
          new_st = harq_rp_pkg::SLOT_EVAL;
          tx_op  = (tx_r == harq_rp_pkg::TX_SAT) ? tx_r : tx_r + CW'(1);
        end
      end
      harq_rp_pkg::OP_FEEDBACK: begin
        if (!pre_eval) begin
          res_nxt.error_code = harq_rp_pkg::ERR_NOT_EVAL;
        end else begin
          res_nxt.fb_process = pid_r;
          res_nxt.out_tag    = cur_tag;
          res_nxt.ack        = cur_dec;
          if (cur_dec) begin
            new_st = harq_rp_pkg::SLOT_CORRECT;
          end else if ({1'b0, tx_r} == {1'b0, max_retx_r} + (CW+1)'(1)) begin
            clr            = 1'b1;
            res_nxt.purged = 1'b1;
          end else begin
            new_st = harq_rp_pkg::SLOT_CORRUPT;
          end
        end
      end
      harq_rp_pkg::OP_EXTRACT: begin
        if (cur_st != harq_rp_pkg::SLOT_CORRECT) begin
          res_nxt.error_code = harq_rp_pkg::ERR_NOT_CORRECT;
        end else begin
          res_nxt.out_tag = cur_tag;
          clr             = 1'b1;
        end
      end
      harq_rp_pkg::OP_POLL: begin
      end
      default: begin
      end
    endcase
    if (clr) begin
      new_st = harq_rp_pkg::SLOT_EMPTY;
      tx_op  = '0;
    end
    res_nxt.slot_state = new_st;
    res_nxt.tx_count   = tx_op;
    // fresh insert has zero age
    res_nxt.evaluated  = (new_st == harq_rp_pkg::SLOT_EVAL) &&
                         (ins_ok ? (eval_r == '0) : age_ok);
    res_nxt.out_bytes  = (new_st == harq_rp_pkg::SLOT_EMPTY) ? '0 :
                         (ins_ok ? in_r.pdu_bytes : cur_bytes);
    if (!cw_ok) begin
      res_nxt = '0;
    end
  end

  assign upd = cmd.commit && cw_ok;

  always_comb begin
    in_nxt = cmd.load_in ? item : in_r;
    tx_nxt = upd ? tx_op : tx_r;
    for (int i = 0; i < NUM_CODEWORDS; i++) begin
      st_nxt[i]    = st_r[i];
      arr_nxt[i]   = arr_r[i];
      dec_nxt[i]   = dec_r[i];
      tag_nxt[i]   = tag_r[i];
      bytes_nxt[i] = bytes_r[i];
      if (upd && hit[i]) begin
        st_nxt[i] = new_st;
        if (ins_ok) begin
          arr_nxt[i]   = in_r.now_time;
          dec_nxt[i]   = in_r.decode_ok;
          tag_nxt[i]   = in_r.pdu_tag;
          bytes_nxt[i] = in_r.pdu_bytes;
        end else if (clr) begin
          arr_nxt[i] = '0;
          dec_nxt[i] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    max_retx_nxt = max_retx_r;
    eval_nxt     = eval_r;
    pid_nxt      = pid_r;
    if (cfg_wr.wr) begin
      unique case (cfg_wr.index)
        harq_rp_pkg::CFG_MAX_RETX:  max_retx_nxt = cfg_wr.data[CW-1:0];
        harq_rp_pkg::CFG_EVAL_INTV: eval_nxt     = cfg_wr.data[harq_rp_pkg::EVAL_W-1:0];
        harq_rp_pkg::CFG_PROC_ID:   pid_nxt      = cfg_wr.data[harq_rp_pkg::PID_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_r       <= '0;
      max_retx_r <= harq_rp_pkg::MAX_RETX_RST;
      eval_r     <= harq_rp_pkg::EVAL_INTV_RST;
      pid_r      <= harq_rp_pkg::PROC_ID_RST;
      for (int i = 0; i < NUM_CODEWORDS; i++) begin
        st_r[i]  <= harq_rp_pkg::SLOT_EMPTY;
        arr_r[i] <= '0;
        dec_r[i] <= 1'b0;
      end
    end else begin
      tx_r       <= tx_nxt;
      max_retx_r <= max_retx_nxt;
      eval_r     <= eval_nxt;
      pid_r      <= pid_nxt;
      for (int i = 0; i < NUM_CODEWORDS; i++) begin
        st_r[i]  <= st_nxt[i];
        arr_r[i] <= arr_nxt[i];
        dec_r[i] <= dec_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    in_r <= in_nxt;
    if (cmd.commit) begin
      res_r <= res_nxt;
    end
    for (int i = 0; i < NUM_CODEWORDS; i++) begin
      tag_r[i]   <= tag_nxt[i];
      bytes_r[i] <= bytes_nxt[i];
    end
  end

endmodule

// ----- tb/harq_rp_checker.sv -----
`timescale 1ns / 100ps

module harq_rp_checker (
  input  logic   clk,
  input  logic   rst_n,
  harq_rp_in_if  in_ch,
  harq_rp_out_if out_ch,
  harq_rp_cfg_if cfg_ch,
  output int     errors,
  output int     pending
);
  import harq_rp_pkg::*;

  localparam int NUM_CW = NUM_CODEWORDS_DEF;

  logic [CNT_W-1:0]   max_retx;
  logic [EVAL_W-1:0]  eval_intv;
  logic [PID_W-1:0]   proc_id;

  logic [1:0]         slot_st   [NUM_CW];
  logic [TIME_W-1:0]  arrive_at [NUM_CW];
  logic               crc_ok    [NUM_CW];
  logic [TAG_W-1:0]   tag_mem   [NUM_CW];
  logic [BYTES_W-1:0] len_mem   [NUM_CW];
  logic [CNT_W-1:0]   tx_cnt;

  result_t due_results [$];

  function automatic logic slot_ripe(int c, logic [TIME_W-1:0] now);
    return slot_st[c] == SLOT_EVAL && (now - arrive_at[c]) >= eval_intv;
  endfunction

  task automatic empty_slot(int c);
    slot_st[c]   = SLOT_EMPTY;
    arrive_at[c] = '0;
    crc_ok[c]    = 1'b0;
    tx_cnt       = '0;
  endtask

  task automatic harq_step(input item_t op, output result_t r);
    int c;
    logic [1:0] st;
    r = '0;
    c = op.codeword;
    if (c >= NUM_CW) return;
    st = slot_st[c];
    case (op.opcode)
      OP_INSERT: begin
        if (op.new_data && st != SLOT_EMPTY) begin
          r.error_code = ERR_NEW_BUSY;
        end else if (!op.new_data && (st == SLOT_EVAL || st == SLOT_CORRECT)) begin
          r.error_code = ERR_RETX_BUSY;
        end else begin
          tag_mem[c]   = op.pdu_tag;
          len_mem[c]   = op.pdu_bytes;
          crc_ok[c]    = op.decode_ok;
          slot_st[c]   = SLOT_EVAL;
          arrive_at[c] = op.now_time;
          if (tx_cnt != TX_SAT) tx_cnt++;
        end
      end
      OP_FEEDBACK: begin
        if (!slot_ripe(c, op.now_time)) begin
          r.error_code = ERR_NOT_EVAL;
        end else begin
          r.fb_process = proc_id;
          r.out_tag    = tag_mem[c];
          r.ack        = crc_ok[c];
          if (crc_ok[c]) begin
            slot_st[c] = SLOT_CORRECT;
          end else begin
            slot_st[c] = SLOT_CORRUPT;
            // 5-bit compare: with max_retx 15 the count never gets there
            if ({1'b0, tx_cnt} == {1'b0, max_retx} + 5'd1) begin
              empty_slot(c);
              r.purged = 1'b1;
            end
          end
        end
      end
      OP_EXTRACT: begin
        if (st != SLOT_CORRECT) begin
          r.error_code = ERR_NOT_CORRECT;
        end else begin
          r.out_tag = tag_mem[c];
          empty_slot(c);
        end
      end
      default: ;
    endcase
    r.slot_state = slot_st[c];
    r.evaluated  = slot_ripe(c, op.now_time);
    r.out_bytes  = (slot_st[c] != SLOT_EMPTY) ? len_mem[c] : '0;
    r.tx_count   = tx_cnt;
  endtask

  task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want, got;
    item_t   op;
    if (!rst_n) begin
      max_retx  = MAX_RETX_RST;
      eval_intv = EVAL_INTV_RST;
      proc_id   = PROC_ID_RST;
      for (int c = 0; c < NUM_CW; c++) begin
        slot_st[c]   = SLOT_EMPTY;
        arrive_at[c] = '0;
        crc_ok[c]    = 1'b0;
        tag_mem[c]   = '0;
        len_mem[c]   = '0;
      end
      tx_cnt = '0;
      due_results.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_MAX_RETX:  max_retx  = cfg_ch.data[CNT_W-1:0];
          CFG_EVAL_INTV: eval_intv = cfg_ch.data[EVAL_W-1:0];
          CFG_PROC_ID:   proc_id   = cfg_ch.data[PID_W-1:0];
          default: ;
        endcase
      end
      // drain before push so an early result cannot match this beat
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.error_code, out_ch.slot_state, out_ch.evaluated, out_ch.ack,
               out_ch.purged, out_ch.fb_process, out_ch.out_tag, out_ch.out_bytes,
               out_ch.tx_count};
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: result beat expected none actual %h", $time, got);
        end else begin
          want = due_results.pop_front();
          cmp_field("error_code", want.error_code, got.error_code);
          cmp_field("slot_state", want.slot_state, got.slot_state);
          cmp_field("evaluated", want.evaluated, got.evaluated);
          cmp_field("ack", want.ack, got.ack);
          cmp_field("purged", want.purged, got.purged);
          cmp_field("fb_process", want.fb_process, got.fb_process);
          cmp_field("out_tag", want.out_tag, got.out_tag);
          cmp_field("out_bytes", want.out_bytes, got.out_bytes);
          cmp_field("tx_count", want.tx_count, got.tx_count);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        op = {in_ch.opcode, in_ch.codeword, in_ch.new_data, in_ch.decode_ok,
              in_ch.pdu_tag, in_ch.pdu_bytes, in_ch.now_time};
        harq_step(op, want);
        due_results.push_back(want);
      end
    end
    pending = due_results.size();
  end

endmodule

// ----- tb/harq_receive_process_core_test.sv -----
`timescale 1ns / 100ps

module harq_receive_process_core_test;
  import harq_rp_pkg::*;

  localparam int NUM_CW = NUM_CODEWORDS_DEF;

  logic clk = 1'b0;
  logic rst_n;
  int   errors;
  int   pending;

  harq_rp_in_if  in_ch ();
  harq_rp_out_if out_ch ();
  harq_rp_cfg_if cfg_ch ();

  harq_receive_process_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  harq_rp_checker chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_ch  (cfg_ch),
    .errors  (errors),
    .pending (pending)
  );

  always #10 clk = ~clk;

  // stimulus-side view of the slots, only used to steer the random ops
  logic [1:0]        sh_st  [NUM_CW];
  logic              sh_ok  [NUM_CW];
  logic [TIME_W-1:0] sh_arr [NUM_CW];
  logic [CNT_W-1:0]  sh_tx;
  logic [CNT_W-1:0]  cur_mr;
  logic [EVAL_W-1:0] cur_ev;
  logic [TIME_W-1:0] clock_now;
  int                ok_pct;
  int                send_cnt;
  int                gap_odds;
  logic              calm;
  logic              squeeze_req;

  function automatic item_t make_item(logic [1:0] op, logic cw, logic ndi, logic dok,
                                      logic [TAG_W-1:0] tag, logic [BYTES_W-1:0] nbytes,
                                      logic [TIME_W-1:0] now);
    item_t it;
    it.opcode    = op;
    it.codeword  = cw;
    it.new_data  = ndi;
    it.decode_ok = dok;
    it.pdu_tag   = tag;
    it.pdu_bytes = nbytes;
    it.now_time  = now;
    return it;
  endfunction

  function automatic void note_op(item_t it);
    int c;
    c = it.codeword;
    case (it.opcode)
      OP_INSERT: begin
        if (it.new_data ? sh_st[c] == SLOT_EMPTY
                        : (sh_st[c] == SLOT_EMPTY || sh_st[c] == SLOT_CORRUPT)) begin
          sh_st[c]  = SLOT_EVAL;
          sh_ok[c]  = it.decode_ok;
          sh_arr[c] = it.now_time;
          if (sh_tx != TX_SAT) sh_tx++;
        end
      end
      OP_FEEDBACK: begin
        if (sh_st[c] == SLOT_EVAL && it.now_time - sh_arr[c] >= cur_ev) begin
          if (sh_ok[c]) begin
            sh_st[c] = SLOT_CORRECT;
          end else if ({1'b0, sh_tx} == {1'b0, cur_mr} + 5'd1) begin
            sh_st[c] = SLOT_EMPTY;
            sh_tx    = '0;
          end else begin
            sh_st[c] = SLOT_CORRUPT;
          end
        end
      end
      OP_EXTRACT: begin
        if (sh_st[c] == SLOT_CORRECT) begin
          sh_st[c] = SLOT_EMPTY;
          sh_tx    = '0;
        end
      end
      default: ;
    endcase
  endfunction

  // mostly the next legal step of a transmission on a random codeword, some noise
  function automatic item_t next_item();
    int c;
    int pick;
    item_t it;
    c = $urandom_range(0, NUM_CW - 1);
    pick = $urandom_range(0, 9);
    clock_now += $urandom_range(0, 3);
    it = make_item(OP_POLL, 1'(c), 1'($urandom_range(0, 1)), $urandom_range(0, 99) < ok_pct,
                   $urandom, 16'($urandom), clock_now);
    if ($urandom_range(0, 99) < 15) begin
      it.opcode = 2'($urandom_range(0, 3));
      if (pick < 5) it.now_time = $urandom;
    end else begin
      case (sh_st[c])
        SLOT_EMPTY: it.opcode = OP_INSERT;
        SLOT_CORRUPT: begin
          it.opcode   = OP_INSERT;
          it.new_data = 1'b0;
        end
        SLOT_CORRECT: it.opcode = (pick < 2) ? OP_POLL : OP_EXTRACT;
        default: begin
          it.opcode   = (pick < 2) ? OP_POLL : OP_FEEDBACK;
          it.now_time = sh_arr[c] + cur_ev + $urandom_range(0, 2);
          // polls straddle the point where the interval elapses
          if (pick < 2) it.now_time -= 1;
          else if (pick == 2 && cur_ev != 0)
            it.now_time = sh_arr[c] + $urandom_range(0, cur_ev - 1);
        end
      endcase
    end
    return it;
  endfunction

  task automatic send_item(input item_t it);
    if (send_cnt % 50 == 0) begin
      case ($urandom_range(0, 2))
        0: gap_odds = 0;
        1: gap_odds = 3;
        default: gap_odds = 8;
      endcase
    end
    send_cnt++;
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.opcode, in_ch.codeword, in_ch.new_data, in_ch.decode_ok,
     in_ch.pdu_tag, in_ch.pdu_bytes, in_ch.now_time} <= it;
    do @(posedge clk); while (!in_ch.ready);
    note_op(it);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [CNT_W-1:0] mr, input logic [EVAL_W-1:0] ev,
                          input logic [PID_W-1:0] pid);
    write_reg(CFG_MAX_RETX, CFG_DATA_W'(mr));
    write_reg(CFG_EVAL_INTV, ev);
    write_reg(CFG_PROC_ID, CFG_DATA_W'(pid));
    cur_mr = mr;
    cur_ev = ev;
  endtask

  // block is idle once every result is back; a few spare cycles on top
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // receiver side: random stall bursts, quiet spans, one long hold-off
  initial begin : result_side
    int left;
    int odds;
    int span;
    logic squeeze_done;
    left = 0;
    odds = 0;
    span = 0;
    squeeze_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (span == 0) begin
        span = 100;
        case ($urandom_range(0, 2))
          0: odds = 0;
          1: odds = 3;
          default: odds = 10;
        endcase
      end
      span--;
      if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        left = 80;
      end else if (left == 0 && !calm && odds != 0 && $urandom_range(1, odds) == 1) begin
        left = $urandom_range(1, 12);
      end
      if (left > 0) begin
        out_ch.ready <= 1'b0;
        left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int p;
    int n;
    logic [CNT_W-1:0]  mr;
    logic [EVAL_W-1:0] ev;
    logic [PID_W-1:0]  pid;
    for (int c = 0; c < NUM_CW; c++) begin
      sh_st[c]  = SLOT_EMPTY;
      sh_ok[c]  = 1'b0;
      sh_arr[c] = '0;
    end
    sh_tx       = '0;
    cur_mr      = MAX_RETX_RST;
    cur_ev      = EVAL_INTV_RST;
    clock_now   = '0;
    ok_pct      = 50;
    send_cnt    = 0;
    gap_odds    = 0;
    calm        = 1'b0;
    squeeze_req = 1'b0;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    {in_ch.opcode, in_ch.codeword, in_ch.new_data, in_ch.decode_ok,
     in_ch.pdu_tag, in_ch.pdu_bytes, in_ch.now_time} <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_regs(4'd1, 16'd5, 4'd15);
    send_item(make_item(OP_POLL, 0, 0, 0, 32'h0, 16'h0, 32'd0));
    send_item(make_item(OP_EXTRACT, 0, 0, 0, 32'h0, 16'h0, 32'd0));
    send_item(make_item(OP_FEEDBACK, 1, 0, 0, 32'h0, 16'h0, 32'd0));
    send_item(make_item(OP_INSERT, 0, 1, 0, 32'hFFFF_FFFF, 16'hFFFF, 32'd100));
    send_item(make_item(OP_INSERT, 0, 1, 1, 32'h1234_5678, 16'h0001, 32'd101));
    send_item(make_item(OP_INSERT, 0, 0, 1, 32'h1234_5678, 16'h0001, 32'd102));
    send_item(make_item(OP_FEEDBACK, 0, 0, 0, 32'h0, 16'h0, 32'd104));
    send_item(make_item(OP_POLL, 0, 0, 0, 32'h0, 16'h0, 32'd105));
    send_item(make_item(OP_FEEDBACK, 0, 0, 0, 32'h0, 16'h0, 32'd105));
    // retransmission reaches max_retx + 1 and the NACK purges the slot
    send_item(make_item(OP_INSERT, 0, 0, 0, 32'h0, 16'h0, 32'd200));
    send_item(make_item(OP_FEEDBACK, 0, 0, 0, 32'h0, 16'h0, 32'd205));
    // retransmission into an empty slot, arrival just before the time wraps
    send_item(make_item(OP_INSERT, 1, 0, 1, 32'hA5A5_5A5A, 16'h7FFF, 32'hFFFF_FFFE));
    send_item(make_item(OP_POLL, 1, 0, 0, 32'h0, 16'h0, 32'd2));
    send_item(make_item(OP_FEEDBACK, 1, 0, 0, 32'h0, 16'h0, 32'd3));
    send_item(make_item(OP_INSERT, 1, 0, 0, 32'h0, 16'h0, 32'd4));
    send_item(make_item(OP_INSERT, 1, 1, 0, 32'h0, 16'h0, 32'd5));
    send_item(make_item(OP_FEEDBACK, 1, 0, 0, 32'h0, 16'h0, 32'd10));
    send_item(make_item(OP_EXTRACT, 1, 0, 0, 32'h0, 16'h0, 32'd11));
    send_item(make_item(OP_INSERT, 0, 1, 1, 32'h8000_0001, 16'h8000, 32'd0));
    send_item(make_item(OP_EXTRACT, 0, 0, 0, 32'h0, 16'h0, 32'd1));
    send_item(make_item(OP_FEEDBACK, 0, 0, 0, 32'h0, 16'h0, 32'd5));
    send_item(make_item(OP_EXTRACT, 0, 0, 0, 32'h0, 16'h0, 32'd6));
    send_item(make_item(OP_POLL, 1, 0, 0, 32'h0, 16'h0, 32'hFFFF_FFFF));

    for (p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: begin mr = 4'd3;  ev = 16'd3;     pid = 4'd5;  ok_pct = 50; n = 250; end
        // no ACKs: the transmission count saturates, never purged at max_retx 15
        1: begin mr = 4'd15; ev = 16'd0;     pid = 4'd0;  ok_pct = 0;  n = 150; end
        2: begin
          mr = 4'd14; ev = 16'hFFFF; pid = 4'd15; ok_pct = 25; n = 150;
          clock_now = 32'hFFFF_FFC0;
        end
        3: begin mr = 4'd0;  ev = 16'd1;     pid = 4'd9;  ok_pct = 50; n = 250; end
        4: begin mr = 4'd7;  ev = 16'd20;    pid = 4'd3;  ok_pct = 75; n = 250; end
        default: begin
          mr = 4'd2; ev = 16'd2; pid = 4'd12; ok_pct = 50; n = 150;
          calm = 1'b1;
        end
      endcase
      set_regs(mr, ev, pid);
      for (int k = 0; k < n; k++) begin
        if (p == 1 && k == 30) squeeze_req = 1'b1;
        send_item(next_item());
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #8_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/harq_rp_pkg.sv
hw/rtl/harq_rp_ifs.sv
hw/rtl/harq_rp_ctrl.sv
hw/rtl/harq_rp_dp.sv
hw/rtl/harq_receive_process_core.sv
tb/harq_rp_checker.sv
tb/harq_receive_process_core_test.sv
